>>> src/ssfm_pkg.sv
package ssfm_pkg;

   localparam int NeedleBytes = 16;
   localparam int CsrAddrW    = 5;
   localparam int CsrDataW    = 64;
   localparam int PosW        = 16;
   localparam int LenW        = 5;

   typedef enum logic [1:0] {
      STATUS_FOUND      = 2'd0,
      STATUS_NOT_FOUND  = 2'd1,
      STATUS_OFFSET_OOR = 2'd2,
      STATUS_EMPTY      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_NEEDLE_LOW  = 2'd0,
      REG_NEEDLE_HIGH = 2'd1,
      REG_NEEDLE_LEN  = 2'd2,
      REG_START_OFF   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type      status;
      logic [PosW-1:0] match_position;
   } rsp_type;

   // Needle byte k sits at needle[k].
   typedef struct packed {
      logic [NeedleBytes-1:0][7:0] needle;
      logic [LenW-1:0]             needle_length;
      logic [PosW-1:0]             start_offset;
   } cfg_type;

endpackage

>>> src/substring_first_match_search.sv
// Streaming first-match substring search. The haystack enters one byte per
// item, and an item can be accepted in every clock cycle; the byte on which
// last_byte is set produces one result item, registered and shown on the
// cycle after that byte is accepted, after which the block is clean for the
// next haystack. The search window is a row of MAX_NEEDLE byte cells that
// shift on every kept byte and each compare their byte against the
// needle byte that lines up with them, so a whole window compare completes
// in the same cycle as the shift. The single result register decides the
// rate only when results pile up: while a result waits to be taken, new
// bytes are held off. Bytes past MAX_HAYSTACK are dropped but a last byte
// still closes the haystack. Needle and offset registers are written
// through the 64-bit register port at byte addresses 0, 8, 16 and 24.
module substring_first_match_search #(
   parameter int MAX_NEEDLE   = 16,
   parameter int MAX_HAYSTACK = 65536
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ssfm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ssfm_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ssfm_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [ssfm_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [ssfm_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                            csr_pready
);

   localparam int SeenW = $clog2(MAX_HAYSTACK + 1);
   localparam int CmpW  = (SeenW > ssfm_pkg::PosW) ? SeenW : ssfm_pkg::PosW;

   ssfm_pkg::cfg_type          cfg;
   logic [SeenW-1:0]           seen_ff, seen_in, seen_new;
   logic                       match_ff, match_in, match_new;
   logic [ssfm_pkg::PosW-1:0]  idx_ff, idx_in, idx_new;
   logic                       rsp_valid_ff, rsp_valid_in;
   ssfm_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic                       room;
   logic                       shift;
   logic                       finish;
   logic                       len_ok;
   logic                       latch_now;
   logic [CmpW-1:0]            seen_ext;
   logic [CmpW-1:0]            len_ext;
   logic [CmpW-1:0]            off_ext;
   logic [CmpW-1:0]            cand;
   logic [MAX_NEEDLE-1:0][7:0] cell_byte;
   logic [MAX_NEEDLE-1:0]      cell_hit;

   ssfm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign room      = (seen_ff < SeenW'(MAX_HAYSTACK));
   assign shift     = accept && room;
   assign finish    = accept && req_data.last_byte;

   for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_cell
      logic [7:0] left_byte;
      if (i == 0) begin : g_head
         assign left_byte = req_data.data_byte;
      end else begin : g_body
         assign left_byte = cell_byte[i-1];
      end
      ssfm_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .clear     (finish),
         .left_byte (left_byte),
         .cfg       (cfg),
         .byte_out  (cell_byte[i]),
         .hit       (cell_hit[i])
      );
   end

   assign seen_new = room ? seen_ff + SeenW'(1) : seen_ff;
   assign seen_ext = CmpW'(seen_new);
   assign len_ext  = CmpW'(cfg.needle_length);
   assign off_ext  = CmpW'(cfg.start_offset);
   assign cand     = seen_ext - len_ext;

   assign len_ok = (cfg.needle_length != '0)
                && (len_ext <= CmpW'(MAX_NEEDLE))
                && (seen_ext >= len_ext);

   assign latch_now = shift && !match_ff && len_ok && (cand >= off_ext) && (&cell_hit);
   assign match_new = match_ff || latch_now;
   assign idx_new   = latch_now ? cand[ssfm_pkg::PosW-1:0] : idx_ff;

   always_comb begin
      rsp_data_in.match_position = '0;
      if (off_ext >= seen_ext) begin
         rsp_data_in.status = ssfm_pkg::STATUS_OFFSET_OOR;
      end else if (cfg.needle_length == '0) begin
         rsp_data_in.status = ssfm_pkg::STATUS_EMPTY;
      end else if (match_new) begin
         rsp_data_in.status         = ssfm_pkg::STATUS_FOUND;
         rsp_data_in.match_position = idx_new;
      end else begin
         rsp_data_in.status = ssfm_pkg::STATUS_NOT_FOUND;
      end
   end

   always_comb begin
      seen_in  = seen_ff;
      match_in = match_ff;
      idx_in   = idx_ff;
      if (finish) begin
         seen_in  = '0;
         match_in = 1'b0;
         idx_in   = '0;
      end else if (accept) begin
         seen_in  = seen_new;
         match_in = match_new;
         idx_in   = idx_new;
      end
   end

   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         match_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         match_ff     <= match_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SeenW'(MAX_HAYSTACK))
      else $error("byte count ran past the haystack limit");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      finish |=> (seen_ff == '0) && !match_ff && (idx_ff == '0))
      else $error("search state not cleared after the last byte");

   a_match_needs_bytes: assert property (@(posedge clock) disable iff (reset)
      match_ff |-> (seen_ff != '0))
      else $error("match latched with no bytes counted");

   a_position_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != ssfm_pkg::STATUS_FOUND)
         |-> (rsp_data_ff.match_position == '0))
      else $error("nonzero position on a result that is not a match");

endmodule

>>> src/ssfm_cell.sv
module ssfm_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              clear,
   input  logic [7:0]        left_byte,
   input  ssfm_pkg::cfg_type cfg,
   output logic [7:0]        byte_out,
   output logic              hit
);

   logic [7:0]                  byte_ff;
   logic [7:0]                  byte_in;
   logic [7:0]                  window_byte;
   logic [ssfm_pkg::LenW-1:0]   needle_idx;
   logic                        unused_pos;

   // The compare looks at the window as it stands after this item's shift.
   assign window_byte = shift ? left_byte : byte_ff;
   assign needle_idx  = cfg.needle_length - ssfm_pkg::LenW'(1) - ssfm_pkg::LenW'(IDX);
   assign unused_pos  = (ssfm_pkg::LenW'(IDX) >= cfg.needle_length);

   always_comb begin
      hit = unused_pos || (window_byte == cfg.needle[needle_idx[3:0]]);
   end

   always_comb begin
      if (clear) begin
         byte_in = 8'd0;
      end else begin
         byte_in = window_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

>>> src/ssfm_csr.sv
module ssfm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ssfm_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [ssfm_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [ssfm_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                            csr_pready,
   output ssfm_pkg::cfg_type               cfg
);

   logic [63:0]               low_ff, low_in;
   logic [63:0]               high_ff, high_in;
   logic [ssfm_pkg::LenW-1:0] len_ff, len_in;
   logic [ssfm_pkg::PosW-1:0] off_ff, off_in;
   logic                      wr_en;
   ssfm_pkg::reg_index_type   reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = ssfm_pkg::reg_index_type'(csr_paddr[4:3]);

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      len_in  = len_ff;
      off_in  = off_ff;
      if (wr_en) begin
         unique case (reg_sel)
            ssfm_pkg::REG_NEEDLE_LOW:  low_in  = csr_pwdata;
            ssfm_pkg::REG_NEEDLE_HIGH: high_in = csr_pwdata;
            ssfm_pkg::REG_NEEDLE_LEN:  len_in  = csr_pwdata[ssfm_pkg::LenW-1:0];
            ssfm_pkg::REG_START_OFF:   off_in  = csr_pwdata[ssfm_pkg::PosW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         ssfm_pkg::REG_NEEDLE_LOW:  csr_prdata = low_ff;
         ssfm_pkg::REG_NEEDLE_HIGH: csr_prdata = high_ff;
         ssfm_pkg::REG_NEEDLE_LEN:  csr_prdata = ssfm_pkg::CsrDataW'(len_ff);
         ssfm_pkg::REG_START_OFF:   csr_prdata = ssfm_pkg::CsrDataW'(off_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= 64'd0;
         high_ff <= 64'd0;
         len_ff  <= ssfm_pkg::LenW'(1);
         off_ff  <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
         len_ff  <= len_in;
         off_ff  <= off_in;
      end
   end

   assign cfg.needle        = {high_ff, low_ff};
   assign cfg.needle_length = len_ff;
   assign cfg.start_offset  = off_ff;

endmodule
